[rtl/planar_bitmap_rle_decoder_defines.svh]
// Assertion macros used by the decoder's checker file.
`ifndef PLANAR_BITMAP_RLE_DECODER_DEFINES_SVH
`define PLANAR_BITMAP_RLE_DECODER_DEFINES_SVH

// Clocked property check, held off while reset is asserted.
`define PBRD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property check that also holds during reset.
`define PBRD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pbrd_pkg.sv]
// Types and constants shared by the decoder modules.
package pbrd_pkg;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  // One queued transaction: a run result, an end marker, or both.
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] count;
    logic [1:0] plane;
    logic       has_run;
    logic       has_end;
    logic       done;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[rtl/planar_bitmap_rle_decoder.sv]
// Planar bitmap run-length decoder: parser, entry queue and result emitter.
//
// Input channel: one compressed byte per transaction on in_byte_i under
// in_valid_i/in_ready_o. Each plane is a 16-bit little-endian size followed
// by run headers and run data; PLANE_COUNT planes make one image.
// Output channel: one result per transaction under out_valid_o/out_ready_i:
// pixel_value_o repeated repeat_count_o times, or an end-of-plane marker with
// repeat_count_o = 0, plane_number_o naming the plane and image_done_o set on
// the marker of the last plane.
// Path: an accepted byte's result is written into the entry queue and then
// loaded into the output register, from which the receiver takes it.
// Throughput: one byte per cycle while the queue is not full; a byte that
// ends both a run and a plane yields two results, which the emitter sends one
// after the other, so the output port (one result per cycle) sets the sustained rate.
// Reset clears the parser to expect a size low byte of plane 0 and empties
// the queue and output register.
// When the receiver stalls, the output register holds its result, the
// four-entry queue fills, and in_ready_o drops once it is full.
module planar_bitmap_rle_decoder #(
  parameter int PLANE_COUNT = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] pixel_value_o,
  output logic [7:0] repeat_count_o,
  output logic [1:0] plane_number_o,
  output logic       image_done_o
);
  import pbrd_pkg::*;

  logic          push;
  logic          pop;
  entry_t        push_entry;
  entry_t        head;
  queue_status_t q_status;

  pbrd_front #(
    .PLANE_COUNT(PLANE_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_entry_o(push_entry)
  );

  pbrd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  pbrd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_value_o (pixel_value_o),
    .repeat_count_o(repeat_count_o),
    .plane_number_o(plane_number_o),
    .image_done_o  (image_done_o)
  );

endmodule

[rtl/pbrd_front.sv]
// Byte parser: tracks plane size and run state, emits queue entries.
module pbrd_front #(
  parameter int PLANE_COUNT = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  pbrd_pkg::queue_status_t q_status_i,
  output logic            push_o,
  output pbrd_pkg::entry_t push_entry_o
);
  import pbrd_pkg::*;

  localparam int PlaneW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int PcW    = PlaneW + 1;

  localparam logic [2:0] PhSizeLo  = 3'd0;
  localparam logic [2:0] PhSizeHi  = 3'd1;
  localparam logic [2:0] PhHeader  = 3'd2;
  localparam logic [2:0] PhRepeat  = 3'd3;
  localparam logic [2:0] PhLiteral = 3'd4;

  logic [2:0]        phase_q, phase_d;
  logic [7:0]        size_lo_q, size_lo_d;
  logic [15:0]       plane_bytes_q, plane_bytes_d;
  logic [16:0]       consumed_q, consumed_d;
  logic [7:0]        lit_left_q, lit_left_d;
  logic [PlaneW-1:0] plane_q, plane_d;

  logic              fire;
  logic [16:0]       consumed_inc;
  logic              at_end;
  logic              last_plane;
  logic [PlaneW-1:0] plane_next;
  logic [PlaneW+1:0] plane_ext;
  logic [7:0]        lit_dec;
  entry_t            entry;

  assign in_ready_o = !q_status_i.full;
  assign fire       = in_valid_i && in_ready_o;

  assign consumed_inc = (consumed_q != '1) ? consumed_q + 17'd1 : consumed_q;
  assign at_end       = consumed_inc >= {1'b0, plane_bytes_q};
  assign last_plane   = ({1'b0, plane_q} + PcW'(1)) >= PcW'(PLANE_COUNT);
  assign plane_next   = last_plane ? '0 : plane_q + PlaneW'(1);
  assign plane_ext    = {2'b00, plane_q};
  assign lit_dec      = (lit_left_q == 8'd0) ? 8'd0 : lit_left_q - 8'd1;

  always_comb begin
    phase_d       = phase_q;
    size_lo_d     = size_lo_q;
    plane_bytes_d = plane_bytes_q;
    consumed_d    = consumed_q;
    lit_left_d    = lit_left_q;
    plane_d       = plane_q;
    entry.value   = in_byte_i;
    entry.count   = 8'd1;
    entry.plane   = plane_ext[1:0];
    entry.has_run = 1'b0;
    entry.has_end = 1'b0;
    entry.done    = last_plane;
    case (phase_q)
      PhSizeHi: begin
        plane_bytes_d = {in_byte_i, size_lo_q};
        consumed_d    = '0;
        if ({in_byte_i, size_lo_q} == 16'd0) begin
          entry.has_end = 1'b1;
          plane_d       = plane_next;
          phase_d       = PhSizeLo;
        end else begin
          phase_d = PhHeader;
        end
      end
      PhHeader: begin
        consumed_d = consumed_inc;
        if (in_byte_i[7]) begin
          lit_left_d = 8'(9'd257 - {1'b0, in_byte_i});
          phase_d    = PhRepeat;
        end else begin
          lit_left_d = in_byte_i + 8'd1;
          phase_d    = PhLiteral;
        end
      end
      PhRepeat: begin
        consumed_d    = consumed_inc;
        entry.has_run = 1'b1;
        entry.count   = lit_left_q;
        lit_left_d    = 8'd0;
        if (at_end) begin
          entry.has_end = 1'b1;
          plane_d       = plane_next;
          phase_d       = PhSizeLo;
        end else begin
          phase_d = PhHeader;
        end
      end
      PhLiteral: begin
        consumed_d    = consumed_inc;
        entry.has_run = 1'b1;
        lit_left_d    = lit_dec;
        if (lit_dec == 8'd0) begin
          if (at_end) begin
            entry.has_end = 1'b1;
            plane_d       = plane_next;
            phase_d       = PhSizeLo;
          end else begin
            phase_d = PhHeader;
          end
        end
      end
      default: begin
        size_lo_d = in_byte_i;
        phase_d   = PhSizeHi;
      end
    endcase
  end

  assign push_o       = fire && (entry.has_run || entry.has_end);
  assign push_entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhSizeLo;
      size_lo_q     <= '0;
      plane_bytes_q <= '0;
      consumed_q    <= '0;
      lit_left_q    <= '0;
      plane_q       <= '0;
    end else if (fire) begin
      phase_q       <= phase_d;
      size_lo_q     <= size_lo_d;
      plane_bytes_q <= plane_bytes_d;
      consumed_q    <= consumed_d;
      lit_left_q    <= lit_left_d;
      plane_q       <= plane_d;
    end
  end

endmodule

[rtl/pbrd_queue.sv]
// Short queue of parsed entries between the parser and the emitter.
module pbrd_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  pbrd_pkg::entry_t        push_entry_i,
  input  logic                    pop_i,
  output pbrd_pkg::entry_t        head_o,
  output pbrd_pkg::queue_status_t status_o
);
  import pbrd_pkg::*;

  entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  assign status_o.full  = count_q == (QueuePtrW + 1)'(QueueDepth);
  assign status_o.empty = count_q == '0;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (QueuePtrW + 1)'(1);
        2'b01:   count_q <= count_q - (QueuePtrW + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[rtl/pbrd_back.sv]
// Emitter: splits queued entries into result transactions in an output register.
module pbrd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pbrd_pkg::entry_t        head_i,
  input  pbrd_pkg::queue_status_t q_status_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [7:0]              pixel_value_o,
  output logic [7:0]              repeat_count_o,
  output logic [1:0]              plane_number_o,
  output logic                    image_done_o
);
  import pbrd_pkg::*;

  logic       out_valid_q;
  logic       run_sent_q, run_sent_d;
  logic       load;
  logic       send_run;
  logic [7:0] value_q, count_q;
  logic [1:0] plane_q;
  logic       done_q;

  assign load     = (!out_valid_q || out_ready_i) && !q_status_i.empty;
  // Run result goes first; the end marker of the same entry follows.
  assign send_run = head_i.has_run && !run_sent_q;
  assign pop_o    = load && !(send_run && head_i.has_end);

  always_comb begin
    run_sent_d = run_sent_q;
    if (load) begin
      run_sent_d = send_run && head_i.has_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      run_sent_q  <= 1'b0;
    end else begin
      run_sent_q <= run_sent_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      plane_q <= head_i.plane;
      if (send_run) begin
        value_q <= head_i.value;
        count_q <= head_i.count;
        done_q  <= 1'b0;
      end else begin
        value_q <= 8'd0;
        count_q <= 8'd0;
        done_q  <= head_i.done;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = value_q;
  assign repeat_count_o = count_q;
  assign plane_number_o = plane_q;
  assign image_done_o   = done_q;

endmodule

[rtl/pbrd_checker.sv]
// Port-level checks on the decoder's result channel, bound to the top level.
`include "planar_bitmap_rle_decoder_defines.svh"

module pbrd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] pixel_value_o,
  input logic [7:0] repeat_count_o,
  input logic       image_done_o
);

  // Hold a stalled transaction.
  `PBRD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")

  // End markers carry a zero pixel.
  `PBRD_ASSERT(a_marker_zero, clk_i, rst_ni, out_valid_o && repeat_count_o == 8'd0 |-> pixel_value_o == 8'd0, "end marker with nonzero pixel")

  // Image completion is flagged on end markers only.
  `PBRD_ASSERT(a_done_on_marker, clk_i, rst_ni, out_valid_o && image_done_o |-> repeat_count_o == 8'd0, "image done on a run result")

  // Run counts never exceed the longest repeat.
  `PBRD_ASSERT_ALWAYS(a_count_range, clk_i, out_valid_o && rst_ni |-> repeat_count_o <= 8'd129, "repeat count out of range")

endmodule

bind planar_bitmap_rle_decoder pbrd_checker u_pbrd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_value_o (pixel_value_o),
  .repeat_count_o(repeat_count_o),
  .image_done_o  (image_done_o)
);

[dv/tb_top.sv]
// Testbench for planar_bitmap_rle_decoder: random byte stream, shadow decoder, result checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int Planes      = 4;
  localparam int IdlePct     = 27;
  localparam int TargetItems = 650;
  localparam int StallLimit  = 4000;
  localparam int QuietStart  = 300;
  localparam int QuietEnd    = 700;
  localparam int TailCycles  = 16;

  typedef enum logic [2:0] {
    PH_SIZE_LO,
    PH_SIZE_HI,
    PH_HEADER,
    PH_REPEAT,
    PH_LITERAL
  } dec_phase_e;

  typedef struct {
    logic [7:0] value;
    logic [7:0] count;
    logic [1:0] plane;
    logic       done;
  } run_result_t;

  typedef struct {
    logic [7:0] data;
    bit         drain_first;
  } feed_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] pixel_value_o;
  logic [7:0] repeat_count_o;
  logic [1:0] plane_number_o;
  logic       image_done_o;

  feed_item_t  byte_feed[$];
  run_result_t expected_runs[$];
  int          items_queued = 0;
  int          err_cnt = 0;
  int          cyc = 0;
  int          stall_cycles = 0;
  bit          in_taken = 1'b0;

  // Shadow decoder state
  dec_phase_e  dec_phase = PH_SIZE_LO;
  logic [7:0]  size_lo = '0;
  logic [15:0] plane_size = '0;
  logic [16:0] consumed = '0;
  logic [7:0]  run_left = '0;
  logic [1:0]  plane_idx = '0;

  planar_bitmap_rle_decoder #(
    .PLANE_COUNT(Planes)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .pixel_value_o  (pixel_value_o),
    .repeat_count_o (repeat_count_o),
    .plane_number_o (plane_number_o),
    .image_done_o   (image_done_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic push_run(input logic [7:0] value, input logic [7:0] count, input logic done);
    run_result_t r;
    r.value = value;
    r.count = count;
    r.plane = plane_idx;
    r.done  = done;
    expected_runs.push_back(r);
  endtask

  // At a header boundary: close the plane once its size is reached.
  task automatic close_plane_if_full();
    logic last;
    if (consumed >= {1'b0, plane_size}) begin
      last = (int'(plane_idx) + 1 >= Planes);
      push_run(8'h00, 8'h00, last);
      plane_idx = last ? 2'd0 : plane_idx + 2'd1;
      dec_phase = PH_SIZE_LO;
    end else begin
      dec_phase = PH_HEADER;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    if (dec_phase != PH_SIZE_LO && dec_phase != PH_SIZE_HI && consumed != 17'h1FFFF)
      consumed++;
    case (dec_phase)
      PH_SIZE_HI: begin
        plane_size = {b, size_lo};
        consumed = '0;
        close_plane_if_full();
      end
      PH_HEADER: begin
        if (b[7]) begin
          run_left = 8'(9'd257 - {1'b0, b});
          dec_phase = PH_REPEAT;
        end else begin
          run_left = b + 8'd1;
          dec_phase = PH_LITERAL;
        end
      end
      PH_REPEAT: begin
        push_run(b, run_left, 1'b0);
        run_left = '0;
        close_plane_if_full();
      end
      PH_LITERAL: begin
        push_run(b, 8'd1, 1'b0);
        if (run_left > 0) run_left--;
        if (run_left == 0) close_plane_if_full();
      end
      default: begin
        size_lo = b;
        dec_phase = PH_SIZE_HI;
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input bit drain_first = 1'b0);
    feed_item_t f;
    f.data = b;
    f.drain_first = drain_first;
    byte_feed.push_back(f);
    items_queued++;
  endtask

  // short_size puts the size inside or at the end of the last run, so that run may cross it.
  task automatic add_plane(input int nruns, input int min_lit, input int max_lit,
                           input bit short_size, input bit oversize, input bit drain_first);
    logic [7:0] body[$];
    int n;
    int sz;
    int last_start;
    last_start = 0;
    for (int r = 0; r < nruns; r++) begin
      last_start = body.size();
      if (min_lit == 0 && $urandom_range(0, 1)) begin
        body.push_back(8'($urandom_range(128, 255)));
        body.push_back(8'($urandom));
      end else begin
        n = $urandom_range(min_lit, max_lit);
        body.push_back(8'(n));
        repeat (n + 1) body.push_back(8'($urandom));
      end
    end
    sz = body.size();
    if (short_size && sz > 0) sz = $urandom_range(last_start + 1, sz);
    if (oversize) sz = sz + $urandom_range(1, 40);
    push_byte(sz[7:0], drain_first);
    push_byte(sz[15:8]);
    foreach (body[i]) push_byte(body[i]);
  endtask

  task automatic add_image(input bit big);
    int k;
    for (int p = 0; p < Planes; p++) begin
      k = $urandom_range(0, 9);
      if (big && p == 0)
        add_plane(2, 127, 127, 1'b0, 1'b0, 1'b0);
      else if (k == 0)
        add_plane(0, 0, 0, 1'b0, 1'b0, p == 0 && $urandom_range(0, 3) == 0);
      else
        add_plane($urandom_range(1, 3), 0, ($urandom_range(0, 19) == 0) ? 127 : 6,
                  k <= 2, 1'b0, p == 0 && $urandom_range(0, 3) == 0);
    end
  endtask

  function automatic bit quiet();
    return cyc >= QuietStart && cyc < QuietEnd;
  endfunction

  // Driver: present a new byte once the previous one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (byte_feed.size() > 0 &&
            (quiet() || $urandom_range(0, 99) >= IdlePct) &&
            !(byte_feed[0].drain_first && expected_runs.size() > 0)) begin
          in_valid <= 1'b1;
          in_byte  <= byte_feed[0].data;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= quiet() || ($urandom_range(0, 99) >= IdlePct);
    end
    in_taken <= 1'b0;
  end

  // Monitor: predict on each input transaction, check each output transaction
  always @(posedge clk_i) begin
    run_result_t e;
    if (rst_ni) begin
      cyc <= cyc + 1;
      if (in_valid && in_ready_o) begin
        decode_byte(in_byte);
        void'(byte_feed.pop_front());
        in_taken <= 1'b1;
      end
      if (out_valid_o && out_ready) begin
        if (expected_runs.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d count=%0d plane=%0d done=%0b",
                                    pixel_value_o, repeat_count_o, plane_number_o,
                                    image_done_o));
        end else begin
          e = expected_runs.pop_front();
          if (pixel_value_o !== e.value)
            report_mismatch($sformatf("pixel_value %0d, want %0d", pixel_value_o, e.value));
          if (repeat_count_o !== e.count)
            report_mismatch($sformatf("repeat_count %0d, want %0d", repeat_count_o, e.count));
          if (plane_number_o !== e.plane)
            report_mismatch($sformatf("plane_number %0d, want %0d", plane_number_o, e.plane));
          if (image_done_o !== e.done)
            report_mismatch($sformatf("image_done %0b, want %0b", image_done_o, e.done));
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    bit big_done;
    big_done = 1'b0;

    // Directed image: zero-size plane, 129-copy repeat, run end with plane
    // end, run crossing the size, last-plane marker and wrap.
    push_byte(8'h00); push_byte(8'h00);
    push_byte(8'h04); push_byte(8'h00);
    push_byte(8'h80); push_byte(8'hFF);
    push_byte(8'h00); push_byte(8'h5A);
    push_byte(8'h02); push_byte(8'h00);
    push_byte(8'h02); push_byte(8'hAA); push_byte(8'h55); push_byte(8'h01);
    push_byte(8'h02); push_byte(8'h00);
    push_byte(8'hFF); push_byte(8'h80);

    // Hold off until the directed results are all in
    add_plane(1, 0, 6, 1'b0, 1'b0, 1'b1);
    add_plane(2, 0, 6, 1'b1, 1'b0, 1'b0);
    add_plane(0, 0, 0, 1'b0, 1'b0, 1'b0);
    add_plane(1, 0, 6, 1'b0, 1'b0, 1'b0);

    while (items_queued < TargetItems) begin
      if (!big_done && items_queued >= TargetItems / 2) begin
        add_image(1'b1);
        big_done = 1'b1;
      end else begin
        add_image(1'b0);
      end
    end

    // Broken tail: oversized plane, then raw noise
    add_plane(2, 0, 6, 1'b0, 1'b1, 1'b1);
    repeat (40) push_byte(8'($urandom));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_feed.size() > 0 || expected_runs.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_runs.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_runs.size()));

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/pbrd_pkg.sv
rtl/pbrd_front.sv
rtl/pbrd_queue.sv
rtl/pbrd_back.sv
rtl/planar_bitmap_rle_decoder.sv
rtl/pbrd_checker.sv
dv/tb_top.sv
